@@ rtl/core/tpdt_pkg.sv @@
// shared types and constants of the two-pass distance transform
// no dependencies; imported by every module of the block but tpdt_ram
package tpdt_pkg;

    localparam int DIST_W     = 8;
    localparam int PIX_W      = 8;
    localparam int COORD_W    = 8;
    localparam int CFG_DATA_W = 9;
    localparam int CFG_IDX_W  = 2;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;

    // reset value of both frame size registers
    localparam logic [CFG_DATA_W-1:0] DIM_RESET = 9'd256;

    localparam logic [DIST_W-1:0] DIST_SAT = 8'hFF;

    // register map of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TARGET = 2'd0,
        CFG_EIGHT  = 2'd1,
        CFG_WIDTH  = 2'd2,
        CFG_HEIGHT = 2'd3
    } t_cfg_idx;

    // opcode of an input transaction
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_READ = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic accept_load;
        logic accept_read;
        logic load_wr;
        logic read_out;
        logic bwd_rd1;
        logic bwd_rd2;
        logic bwd_wr;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic frame_end;
        logic out_free;
        logic bwd_last;
    } t_status;

endpackage

@@ rtl/core/tpdt_ram.sv @@
// generic ram: one write port, two read ports with registered read data
// no dependencies
module tpdt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re0,
    input  logic [$clog2(DEPTH)-1:0] i_raddr0,
    output logic [WIDTH-1:0]         o_rdata0,
    input  logic                     i_re1,
    input  logic [$clog2(DEPTH)-1:0] i_raddr1,
    output logic [WIDTH-1:0]         o_rdata1
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re0) begin
            o_rdata0 <= r_mem[i_raddr0];
        end
        if (i_re1) begin
            o_rdata1 <= r_mem[i_raddr1];
        end
    end

endmodule

@@ rtl/core/tpdt_ctrl.sv @@
// sequencing state machine of the distance transform
// depends on tpdt_pkg (command and status structs)
module tpdt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_op,
    output logic              o_ready,
    output tpdt_pkg::t_cmd    o_cmd,
    input  tpdt_pkg::t_status i_status
);

    import tpdt_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_LOAD  = 6'b000010,
        ST_READ  = 6'b000100,
        ST_B_RD1 = 6'b001000,
        ST_B_RD2 = 6'b010000,
        ST_B_WR  = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign o_ready = (r_state == ST_IDLE);
    assign accept  = i_valid & o_ready;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_op == OP_LOAD) begin
                        o_cmd.accept_load = 1'b1;
                        n_state           = ST_LOAD;
                    end else begin
                        o_cmd.accept_read = 1'b1;
                        n_state           = ST_READ;
                    end
                end
            end
            ST_LOAD: begin
                o_cmd.load_wr = 1'b1;
                n_state       = i_status.frame_end ? ST_B_RD1 : ST_IDLE;
            end
            ST_READ: begin
                // hold the read data until the output register has room
                if (i_status.out_free) begin
                    o_cmd.read_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            ST_B_RD1: begin
                o_cmd.bwd_rd1 = 1'b1;
                n_state       = ST_B_RD2;
            end
            ST_B_RD2: begin
                o_cmd.bwd_rd2 = 1'b1;
                n_state       = ST_B_WR;
            end
            ST_B_WR: begin
                o_cmd.bwd_wr = 1'b1;
                n_state      = i_status.bwd_last ? ST_IDLE : ST_B_RD1;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ rtl/core/tpdt_dpath.sv @@
// datapath of the distance transform: config registers, raster counters,
// distance store and the min/increment logic of both passes
// depends on tpdt_pkg and tpdt_ram
module tpdt_dpath #(
    parameter int MAX_WIDTH  = tpdt_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = tpdt_pkg::DEF_MAX_HEIGHT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [tpdt_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [tpdt_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic [tpdt_pkg::PIX_W-1:0]        i_pixel,
    input  logic                              i_frame_end,
    input  logic [tpdt_pkg::COORD_W-1:0]      i_read_row,
    input  logic [tpdt_pkg::COORD_W-1:0]      i_read_col,
    input  tpdt_pkg::t_cmd                    i_cmd,
    output tpdt_pkg::t_status                 o_status,
    input  logic                              i_ready,
    output logic                              o_valid,
    output logic [tpdt_pkg::DIST_W-1:0]       o_distance,
    output logic                              o_is_target
);

    import tpdt_pkg::*;

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int AW    = RW + CW;
    localparam int DEPTH = 2 ** AW;
    localparam int DW_W  = $clog2(MAX_WIDTH + 1);
    localparam int DW_H  = $clog2(MAX_HEIGHT + 1);
    localparam int DW_M  = (DW_W > DW_H) ? DW_W : DW_H;
    localparam int DW    = (DW_M > CFG_DATA_W) ? DW_M : CFG_DATA_W;

    function automatic logic [DIST_W-1:0] sat_inc(input logic [DIST_W-1:0] d);
        return (d == DIST_SAT) ? DIST_SAT : d + DIST_W'(1);
    endfunction

    function automatic logic [DIST_W-1:0] min2(input logic [DIST_W-1:0] a,
                                               input logic [DIST_W-1:0] b);
        return (a < b) ? a : b;
    endfunction

    // configuration
    logic [PIX_W-1:0]      r_target;
    logic                  r_eight;
    logic [CFG_DATA_W-1:0] r_fw;
    logic [CFG_DATA_W-1:0] r_fh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= '0;
            r_eight  <= 1'b0;
            r_fw     <= DIM_RESET;
            r_fh     <= DIM_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TARGET: r_target <= i_cfg_data[PIX_W-1:0];
                CFG_EIGHT:  r_eight  <= i_cfg_data[0];
                CFG_WIDTH:  r_fw     <= i_cfg_data;
                CFG_HEIGHT: r_fh     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // effective frame size: zero acts as one, clipped to the store size
    logic [DW-1:0] w_eff;
    logic [DW-1:0] h_eff;

    always_comb begin
        if (r_fw == '0) begin
            w_eff = DW'(1);
        end else if (DW'(r_fw) > DW'(MAX_WIDTH)) begin
            w_eff = DW'(MAX_WIDTH);
        end else begin
            w_eff = DW'(r_fw);
        end
        if (r_fh == '0) begin
            h_eff = DW'(1);
        end else if (DW'(r_fh) > DW'(MAX_HEIGHT)) begin
            h_eff = DW'(MAX_HEIGHT);
        end else begin
            h_eff = DW'(r_fh);
        end
    end

    // state registers
    logic [DW-1:0]     r_load_row;
    logic [DW-1:0]     r_load_col;
    logic [DW-1:0]     r_bi;
    logic [DW-1:0]     r_bj;
    logic              r_out_valid;
    // payload registers
    logic              r_hit;
    logic              r_fend;
    logic              r_rd_in;
    logic [DIST_W-1:0] r_left;
    logic [DIST_W-1:0] r_prev_top;
    logic [DIST_W-1:0] r_center;
    logic [DIST_W-1:0] r_bot;
    logic [DIST_W-1:0] r_right;
    logic [DIST_W-1:0] r_dist;
    logic              r_is_t;

    // raster position of the next load, normalized against the frame
    logic [DW-1:0] row_a;
    logic [DW-1:0] row_n;
    logic [DW-1:0] col_n;

    always_comb begin
        if (r_load_col >= w_eff) begin
            col_n = '0;
            row_a = r_load_row + DW'(1);
        end else begin
            col_n = r_load_col;
            row_a = r_load_row;
        end
        row_n = (row_a >= h_eff) ? '0 : row_a;
    end

    logic [RW-1:0] ld_row_idx;
    logic [RW-1:0] ld_top_row;
    logic [CW-1:0] ld_col_idx;
    logic [CW-1:0] ld_col_nxt;
    logic [CW-1:0] ld_col_prv;
    logic          rd_in_frame;

    assign ld_row_idx  = RW'(row_n);
    assign ld_top_row  = ld_row_idx - RW'(1);
    assign ld_col_idx  = CW'(col_n);
    assign ld_col_nxt  = ld_col_idx + CW'(1);
    assign ld_col_prv  = ld_col_idx - CW'(1);
    assign rd_in_frame = (DW'(i_read_row) < h_eff) && (DW'(i_read_col) < w_eff);

    // backward pass coordinates
    logic [RW-1:0] b_row;
    logic [RW-1:0] b_row_dn;
    logic [CW-1:0] b_col;
    logic [CW-1:0] b_col_rt;
    logic [CW-1:0] b_col_lf;

    assign b_row    = RW'(r_bi);
    assign b_row_dn = b_row + RW'(1);
    assign b_col    = CW'(r_bj);
    assign b_col_rt = b_col + CW'(1);
    assign b_col_lf = b_col - CW'(1);

    // distance store
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [DIST_W-1:0] ram_wdata;
    logic              ram_re0;
    logic              ram_re1;
    logic [AW-1:0]     ram_raddr0;
    logic [AW-1:0]     ram_raddr1;
    logic [DIST_W-1:0] ram_rdata0;
    logic [DIST_W-1:0] ram_rdata1;

    tpdt_ram #(
        .WIDTH (DIST_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk    (i_clk),
        .i_we     (ram_we),
        .i_waddr  (ram_waddr),
        .i_wdata  (ram_wdata),
        .i_re0    (ram_re0),
        .i_raddr0 (ram_raddr0),
        .o_rdata0 (ram_rdata0),
        .i_re1    (ram_re1),
        .i_raddr1 (ram_raddr1),
        .o_rdata1 (ram_rdata1)
    );

    always_comb begin
        ram_re0    = 1'b0;
        ram_re1    = 1'b0;
        ram_raddr0 = '0;
        ram_raddr1 = '0;
        if (i_cmd.accept_load) begin
            // top and top-right neighbors; row 0 has no top, so port 0
            // fetches the left neighbor from the store there
            ram_re0    = 1'b1;
            ram_re1    = 1'b1;
            ram_raddr0 = (ld_row_idx == '0) ? {ld_row_idx, ld_col_prv}
                                             : {ld_top_row, ld_col_idx};
            ram_raddr1 = {ld_top_row, ld_col_nxt};
        end else if (i_cmd.accept_read) begin
            ram_re0    = 1'b1;
            ram_raddr0 = {RW'(i_read_row), CW'(i_read_col)};
        end else if (i_cmd.bwd_rd1) begin
            // center and bottom
            ram_re0    = 1'b1;
            ram_re1    = 1'b1;
            ram_raddr0 = {b_row, b_col};
            ram_raddr1 = {b_row_dn, b_col};
        end else if (i_cmd.bwd_rd2) begin
            // bottom-right and bottom-left
            ram_re0    = 1'b1;
            ram_re1    = 1'b1;
            ram_raddr0 = {b_row_dn, b_col_rt};
            ram_raddr1 = {b_row_dn, b_col_lf};
        end
    end

    // forward pass distance
    logic              f_i0;
    logic              f_j0;
    logic              f_jlast;
    logic [DIST_W-1:0] fwd_left;
    logic [DIST_W-1:0] fwd_m;

    assign f_i0    = (r_load_row != '0);
    assign f_j0    = (r_load_col != '0);
    assign f_jlast = (r_load_col == w_eff - DW'(1));
    // a position folded back onto row 0 by a shrunken frame does not follow
    // its left neighbor, so row 0 uses the stored value instead of r_left
    assign fwd_left = f_i0 ? r_left : ram_rdata0;

    always_comb begin
        fwd_m = f_i0 ? sat_inc(ram_rdata0) : DIST_W'(1);
        fwd_m = min2(fwd_m, f_j0 ? sat_inc(fwd_left) : DIST_W'(1));
        if (r_eight && f_i0) begin
            if (f_j0) begin
                fwd_m = min2(fwd_m, sat_inc(r_prev_top));
            end
            if (!f_jlast) begin
                fwd_m = min2(fwd_m, sat_inc(ram_rdata1));
            end
        end
        if (r_hit) begin
            fwd_m = '0;
        end
    end

    // backward pass distance
    logic              b_ilast;
    logic              b_jlast;
    logic              b_j0;
    logic [DIST_W-1:0] bwd_m;

    assign b_ilast = (r_bi == h_eff - DW'(1));
    assign b_jlast = (r_bj == w_eff - DW'(1));
    assign b_j0    = (r_bj != '0);

    always_comb begin
        bwd_m = min2(r_center, b_ilast ? DIST_W'(1) : sat_inc(r_bot));
        bwd_m = min2(bwd_m, b_jlast ? DIST_W'(1) : sat_inc(r_right));
        if (r_eight && !b_ilast) begin
            if (!b_jlast) begin
                bwd_m = min2(bwd_m, sat_inc(ram_rdata0));
            end
            if (b_j0) begin
                bwd_m = min2(bwd_m, sat_inc(ram_rdata1));
            end
        end
        // a zero stays a zero
        if (r_center == '0) begin
            bwd_m = '0;
        end
    end

    always_comb begin
        ram_we    = i_cmd.load_wr | i_cmd.bwd_wr;
        ram_waddr = {b_row, b_col};
        ram_wdata = bwd_m;
        if (i_cmd.load_wr) begin
            ram_waddr = {RW'(r_load_row), CW'(r_load_col)};
            ram_wdata = fwd_m;
        end
    end

    // counters and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_row  <= '0;
            r_load_col  <= '0;
            r_bi        <= '0;
            r_bj        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.accept_load) begin
                r_load_row <= row_n;
                r_load_col <= col_n;
            end
            if (i_cmd.load_wr) begin
                if (r_fend) begin
                    r_load_row <= '0;
                    r_load_col <= '0;
                    r_bi       <= h_eff - DW'(1);
                    r_bj       <= w_eff - DW'(1);
                end else begin
                    r_load_col <= r_load_col + DW'(1);
                end
            end
            if (i_cmd.bwd_wr) begin
                if (r_bj == '0) begin
                    r_bj <= w_eff - DW'(1);
                    r_bi <= r_bi - DW'(1);
                end else begin
                    r_bj <= r_bj - DW'(1);
                end
            end
            if (i_cmd.read_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept_load) begin
            r_hit  <= (i_pixel == r_target);
            r_fend <= i_frame_end;
        end
        if (i_cmd.accept_read) begin
            r_rd_in <= rd_in_frame;
        end
        if (i_cmd.load_wr) begin
            r_left     <= fwd_m;
            r_prev_top <= ram_rdata0;
        end
        if (i_cmd.bwd_rd2) begin
            r_center <= ram_rdata0;
            r_bot    <= ram_rdata1;
        end
        if (i_cmd.bwd_wr) begin
            r_right <= bwd_m;
        end
        if (i_cmd.read_out) begin
            r_dist <= r_rd_in ? ram_rdata0 : '0;
            r_is_t <= r_rd_in && (ram_rdata0 == '0);
        end
    end

    assign o_status.frame_end = r_fend;
    assign o_status.out_free  = !r_out_valid || i_ready;
    assign o_status.bwd_last  = (r_bi == '0) && (r_bj == '0);

    assign o_valid     = r_out_valid;
    assign o_distance  = r_dist;
    assign o_is_target = r_is_t;

endmodule

@@ rtl/core/two_pass_distance_transform_top.sv @@
// top level of the two-pass grassfire distance transform
// depends on tpdt_pkg, tpdt_ctrl, tpdt_dpath (which holds tpdt_ram)

// Grassfire distance transform of one 8-bit frame held in an on-chip store
// of 2**clog2(MAX_HEIGHT) rows by 2**clog2(MAX_WIDTH) columns (one byte per
// pixel, one write port and two registered read ports). Load transactions
// (op 0) deliver pixels in raster order and run the forward pass inline; each
// reads the top neighbors, or the left neighbor on row 0, then computes and
// writes. The load that carries frame_end then starts the backward pass, which
// walks the frame in reverse raster order, reading the center and bottom, then
// the bottom-right and bottom-left neighbors, then computing and writing each
// pixel on the shared store; it keeps the input ready low until the sweep
// ends. Read transactions (op 1) read the store and return the distance
// and the target flag through an output register; while that register is
// full a read waits in its read state and every transaction behind it waits
// too, while loads on their own never wait on the output.
// Configuration writes are registered and are meant for idle periods.
// The store has no reset: reading an entry that no load has written is
// undefined.
module two_pass_distance_transform_top #(
    parameter int MAX_WIDTH  = tpdt_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = tpdt_pkg::DEF_MAX_HEIGHT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration port
    input  logic                            i_cfg_we,
    input  logic [tpdt_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [tpdt_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // input channel
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic                            i_op,
    input  logic [tpdt_pkg::PIX_W-1:0]      i_pixel,
    input  logic                            i_frame_end,
    input  logic [tpdt_pkg::COORD_W-1:0]    i_read_row,
    input  logic [tpdt_pkg::COORD_W-1:0]    i_read_col,
    // output channel
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [tpdt_pkg::DIST_W-1:0]     o_distance,
    output logic                            o_is_target
);

    import tpdt_pkg::*;

    t_cmd    cmd;
    t_status status;

    // sequencer: one transaction at a time, then the backward sweep
    tpdt_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_op     (i_op),
        .o_ready  (o_ready),
        .o_cmd    (cmd),
        .i_status (status)
    );

    // store, counters and distance arithmetic
    tpdt_dpath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_pixel     (i_pixel),
        .i_frame_end (i_frame_end),
        .i_read_row  (i_read_row),
        .i_read_col  (i_read_col),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_ready     (i_ready),
        .o_valid     (o_valid),
        .o_distance  (o_distance),
        .o_is_target (o_is_target)
    );

endmodule

@@ test/two_pass_distance_transform_top_tb.sv @@
// self-checking testbench of the two-pass distance transform top level
// depends on tpdt_pkg and two_pass_distance_transform_top; nothing else
// drives frames and distance reads, predicts every read and checks it
module two_pass_distance_transform_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tpdt_pkg::*;

    // row pitch of the shadow distance map, matches the default store
    localparam int MAP_COLS    = DEF_MAX_WIDTH;
    localparam int MAP_DEPTH   = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;
    // stimulus stops once this many transactions are queued
    localparam int ITEM_GOAL   = 1850;
    // long receiver hold-off, output register fills and loads back up
    localparam int HOLD_CYCLES = 300;
    // far above the slowest legal run
    localparam int CYCLE_LIMIT = 500000;

    // one input transaction
    typedef struct {
        logic               op;
        logic [PIX_W-1:0]   pixel;
        logic               frame_end;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
    } t_dt_txn;

    // one read answer
    typedef struct {
        logic [DIST_W-1:0] distance;
        logic              is_target;
    } t_dt_answer;

    // dut ports, all inputs known from time zero
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  i_valid     = 1'b0;
    logic                  o_ready;
    logic                  i_op        = OP_LOAD;
    logic [PIX_W-1:0]      i_pixel     = '0;
    logic                  i_frame_end = 1'b0;
    logic [COORD_W-1:0]    i_read_row  = '0;
    logic [COORD_W-1:0]    i_read_col  = '0;
    logic                  o_valid;
    logic                  i_ready     = 1'b0;
    logic [DIST_W-1:0]     o_distance;
    logic                  o_is_target;

    two_pass_distance_transform_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_op        (i_op),
        .i_pixel     (i_pixel),
        .i_frame_end (i_frame_end),
        .i_read_row  (i_read_row),
        .i_read_col  (i_read_col),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_distance  (o_distance),
        .o_is_target (o_is_target)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // register copies, shared by predictor and stimulus (changed only while idle)
    logic [PIX_W-1:0]      cfg_target = '0;
    logic                  cfg_eight  = 1'b0;
    logic [CFG_DATA_W-1:0] cfg_width  = DIM_RESET;
    logic [CFG_DATA_W-1:0] cfg_height = DIM_RESET;

    // predictor state: distance map and raster position of the next load
    logic [DIST_W-1:0] dist_map [0:MAP_DEPTH-1];
    int                fw_row = 0;
    int                fw_col = 0;

    // stimulus side shadow: which entries have been loaded, and load position
    bit                ever_loaded [0:MAP_DEPTH-1];
    int                gen_row = 0;
    int                gen_col = 0;

    t_dt_txn           txn_q[$];       // transactions waiting for the driver
    t_dt_answer        answers_q[$];   // predicted read answers, oldest first
    t_dt_txn           drv_cur;

    int  cyc        = 0;
    int  err_cnt    = 0;
    int  n_checked  = 0;
    int  n_loads    = 0;
    int  n_reads    = 0;
    int  n_frames   = 0;
    bit  hold_armed = 1'b0;
    bit  hold_done  = 1'b0;
    int  hold_left  = 0;

    // ------------------------------------------------------------------
    // predictor helpers
    // ------------------------------------------------------------------

    // zero acts as one, anything above the store size acts as the maximum
    function automatic int eff_dim(logic [CFG_DATA_W-1:0] v, int maxv);
        if (v == '0)
            return 1;
        if (int'(v) > maxv)
            return maxv;
        return int'(v);
    endfunction

    function automatic int frame_w();
        return eff_dim(cfg_width, DEF_MAX_WIDTH);
    endfunction

    function automatic int frame_h();
        return eff_dim(cfg_height, DEF_MAX_HEIGHT);
    endfunction

    function automatic int map_at(int r, int c);
        return r * MAP_COLS + c;
    endfunction

    // saturating +1
    function automatic logic [DIST_W-1:0] step_up(logic [DIST_W-1:0] d);
        return (d == DIST_SAT) ? DIST_SAT : d + 1'b1;
    endfunction

    function automatic logic [DIST_W-1:0] min8(logic [DIST_W-1:0] a, logic [DIST_W-1:0] b);
        return (a < b) ? a : b;
    endfunction

    // reverse raster sweep over the configured frame, bottom/right neighbors
    function automatic void grassfire_backward(int w, int h);
        int                idx;
        int                r;
        int                c;
        logic [DIST_W-1:0] m;
        for (int k = w * h; k > 0; k--) begin
            idx = k - 1;
            r   = idx / w;
            c   = idx % w;
            m   = dist_map[map_at(r, c)];
            // a zero entry is a target and stays put
            if (m != '0) begin
                m = min8(m, (r < h - 1) ? step_up(dist_map[map_at(r + 1, c)]) : 8'd1);
                m = min8(m, (c < w - 1) ? step_up(dist_map[map_at(r, c + 1)]) : 8'd1);
                if (cfg_eight && r < h - 1) begin
                    if (c < w - 1)
                        m = min8(m, step_up(dist_map[map_at(r + 1, c + 1)]));
                    if (c > 0)
                        m = min8(m, step_up(dist_map[map_at(r + 1, c - 1)]));
                end
                dist_map[map_at(r, c)] = m;
            end
        end
    endfunction

    // forward step of one pixel load, backward sweep on frame_end
    function automatic void grassfire_load(t_dt_txn t);
        int                w;
        int                h;
        int                r;
        int                c;
        logic [DIST_W-1:0] m;
        w = frame_w();
        h = frame_h();
        // position wraps to the next row, then to row 0
        if (fw_col >= w) begin
            fw_col = 0;
            fw_row++;
        end
        if (fw_row >= h)
            fw_row = 0;
        r = fw_row;
        c = fw_col;
        if (t.pixel == cfg_target) begin
            m = '0;
        end else begin
            m = (r > 0) ? step_up(dist_map[map_at(r - 1, c)]) : 8'd1;
            m = min8(m, (c > 0) ? step_up(dist_map[map_at(r, c - 1)]) : 8'd1);
            if (cfg_eight && r > 0) begin
                if (c > 0)
                    m = min8(m, step_up(dist_map[map_at(r - 1, c - 1)]));
                if (c < w - 1)
                    m = min8(m, step_up(dist_map[map_at(r - 1, c + 1)]));
            end
        end
        dist_map[map_at(r, c)] = m;
        fw_col++;
        if (t.frame_end) begin
            grassfire_backward(w, h);
            fw_row = 0;
            fw_col = 0;
        end
    endfunction

    // outside the frame reads as distance 0, not a target
    function automatic t_dt_answer grassfire_read(logic [COORD_W-1:0] r, logic [COORD_W-1:0] c);
        t_dt_answer a;
        a.distance  = '0;
        a.is_target = 1'b0;
        if (int'(r) < frame_h() && int'(c) < frame_w()) begin
            a.distance  = dist_map[map_at(r, c)];
            a.is_target = (a.distance == '0);
        end
        return a;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // random idle, except in periodic calm stretches
    function automatic bit take_break();
        if (((cyc >> 12) & 3) == 1)
            return 1'b0;
        return $urandom_range(0, 99) < 15;
    endfunction

    // queue a pixel load and track where it lands
    task automatic queue_load(logic [PIX_W-1:0] pix, logic fend);
        t_dt_txn t;
        if (gen_col >= frame_w()) begin
            gen_col = 0;
            gen_row++;
        end
        if (gen_row >= frame_h())
            gen_row = 0;
        ever_loaded[map_at(gen_row, gen_col)] = 1'b1;
        gen_col++;
        if (fend) begin
            gen_row = 0;
            gen_col = 0;
            n_frames++;
        end
        t.op        = OP_LOAD;
        t.pixel     = pix;
        t.frame_end = fend;
        t.row       = COORD_W'($urandom_range(0, 255));
        t.col       = COORD_W'($urandom_range(0, 255));
        txn_q.insert(txn_q.size(), t);
        n_loads++;
    endtask

    task automatic queue_read(int r, int c);
        t_dt_txn t;
        t.op        = OP_READ;
        t.pixel     = PIX_W'($urandom_range(0, 255));
        t.frame_end = 1'($urandom_range(0, 1));
        t.row       = COORD_W'(r);
        t.col       = COORD_W'(c);
        txn_q.insert(txn_q.size(), t);
        n_reads++;
    endtask

    // only entries already loaded, or coordinates outside the frame
    function automatic bit read_allowed(int r, int c);
        if (r >= frame_h() || c >= frame_w())
            return 1'b1;
        return ever_loaded[map_at(r, c)];
    endfunction

    // whole configured frame loaded at least once (early frame_end is safe)
    function automatic bit frame_covered();
        for (int r = 0; r < frame_h(); r++)
            for (int c = 0; c < frame_w(); c++)
                if (!ever_loaded[map_at(r, c)])
                    return 1'b0;
        return 1'b1;
    endfunction

    // mostly inside the frame, a quarter anywhere in the coordinate space
    task automatic queue_random_read();
        int r;
        int c;
        repeat (16) begin
            if ($urandom_range(0, 3) == 0) begin
                r = $urandom_range(0, 255);
                c = $urandom_range(0, 255);
            end else begin
                r = $urandom_range(0, frame_h() - 1);
                c = $urandom_range(0, frame_w() - 1);
            end
            if (read_allowed(r, c)) begin
                queue_read(r, c);
                return;
            end
        end
    endtask

    function automatic logic [PIX_W-1:0] rand_pixel();
        if ($urandom_range(0, 3) == 0)
            return cfg_target;
        return PIX_W'($urandom_range(0, 255));
    endfunction

    // one register write, the copy follows at the edge that takes it
    task automatic set_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            CFG_TARGET: cfg_target = val[PIX_W-1:0];
            CFG_EIGHT:  cfg_eight  = val[0];
            CFG_WIDTH:  cfg_width  = val;
            CFG_HEIGHT: cfg_height = val;
            default: ;
        endcase
    endtask

    task automatic set_frame(int target, int eight, int w, int h);
        set_reg(CFG_TARGET, CFG_DATA_W'(target));
        set_reg(CFG_EIGHT, CFG_DATA_W'(eight));
        set_reg(CFG_WIDTH, CFG_DATA_W'(w));
        set_reg(CFG_HEIGHT, CFG_DATA_W'(h));
    endtask

    // all queued transactions taken, all answers back, then room for a
    // backward sweep that a trailing load may have started
    task automatic wait_idle();
        @(negedge i_clk);
        while (txn_q.size() != 0 || i_valid || answers_q.size() != 0)
            @(negedge i_clk);
        repeat (3 * frame_w() * frame_h() + 16)
            @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // driver: feeds txn_q, predicts each accepted transaction
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || o_ready) begin
            // previous transaction accepted at this edge
            if (i_valid) begin
                if (drv_cur.op == OP_LOAD)
                    grassfire_load(drv_cur);
                else
                    answers_q.insert(answers_q.size(),
                                     grassfire_read(drv_cur.row, drv_cur.col));
            end
            if (txn_q.size() != 0 && !take_break()) begin
                drv_cur = txn_q.pop_front();
                i_valid     <= 1'b1;
                i_op        <= drv_cur.op;
                i_pixel     <= drv_cur.pixel;
                i_frame_end <= drv_cur.frame_end;
                i_read_row  <= drv_cur.row;
                i_read_col  <= drv_cur.col;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: checks each result, drives i_ready with random stalls
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_dt_answer want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (answers_q.size() == 0) begin
                    $error("result with no read pending: distance %0d is_target %0d",
                           o_distance, o_is_target);
                    err_cnt++;
                end else begin
                    want = answers_q.pop_front();
                    n_checked++;
                    if (o_distance !== want.distance) begin
                        $error("distance: expected %0d, actual %0d", want.distance, o_distance);
                        err_cnt++;
                    end
                    if (o_is_target !== want.is_target) begin
                        $error("is_target: expected %0d, actual %0d",
                               want.is_target, o_is_target);
                        err_cnt++;
                    end
                end
            end
            // one long hold-off while a burst of reads is in flight
            if (hold_armed && !hold_done && o_valid) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= !take_break();
            end
        end
    end

    // cycle count and timeout
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cyc);
            $display("two_pass_distance_transform_top_tb: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial begin
        int wv;
        int hv;
        int w;
        int h;
        int sel;
        int kind;
        int npix;
        int nrd;
        int round;
        int eight;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: tiny 3x2 frame, 4-connected, target 0, pixel extremes
        set_frame(0, 0, 3, 2);
        queue_load(8'd0, 1'b0);
        queue_load(8'd255, 1'b0);
        queue_load(8'd7, 1'b0);
        queue_load(8'd1, 1'b0);
        queue_load(8'd0, 1'b0);
        queue_load(8'd128, 1'b1);
        queue_read(0, 0);
        queue_read(1, 2);
        queue_read(2, 0);       // row just past the frame
        queue_read(0, 3);       // column just past the frame
        queue_read(255, 255);
        wait_idle();

        // directed: 8-connected, target 255, frame shrinks in the middle of a load
        set_frame(255, 1, 4, 3);
        queue_load(8'd255, 1'b0);
        queue_load(8'd3, 1'b0);
        queue_load(8'd200, 1'b0);
        queue_load(8'd255, 1'b0);
        queue_load(8'd17, 1'b0);
        wait_idle();
        // position (1,1) falls outside the 2x1 frame and folds back to row 0
        set_reg(CFG_WIDTH, 9'd2);
        set_reg(CFG_HEIGHT, 9'd1);
        queue_load(8'd9, 1'b1);
        queue_read(0, 1);
        queue_read(0, 2);
        wait_idle();

        // directed: early frame_end on a frame whose store is already full
        queue_load(8'd255, 1'b1);
        queue_read(0, 0);
        queue_read(0, 1);
        wait_idle();

        // random frames until the item goal is reached
        round = 0;
        while (n_loads + n_reads < ITEM_GOAL) begin
            kind = 0;   // 0 normal, 1 overlong, 2 early frame_end
            if (round >= 2) begin
                sel  = $urandom_range(0, 99);
                kind = (sel < 80) ? 0 : (sel < 90) ? 1 : 2;
            end
            eight = $urandom_range(0, 1);
            if (kind == 2) begin
                // keep the frame size, the store covers it already
                wv = cfg_width;
                hv = cfg_height;
            end else if (round == 0) begin
                wv    = 256;      // widest frame, single row
                hv    = 1;
                eight = 1;
            end else if (round == 1) begin
                wv = 0;           // width 0 acts as 1
                hv = 511;         // oversized height acts as 256
            end else begin
                sel = $urandom_range(0, 99);
                if (sel < 85) begin
                    wv = $urandom_range(1, 10);
                    hv = $urandom_range(1, 10);
                end else if (sel < 89) begin
                    wv = 256;
                    hv = 1;
                end else if (sel < 93) begin
                    wv = $urandom_range(1, 2);
                    hv = 256;
                end else if (sel < 97) begin
                    wv = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(257, 511);
                    hv = (wv == 0) ? $urandom_range(1, 8) : 1;
                end else begin
                    hv = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(257, 511);
                    wv = (hv == 0) ? $urandom_range(1, 8) : 1;
                end
            end
            set_frame($urandom_range(0, 255), eight, wv, hv);
            w = frame_w();
            h = frame_h();
            if (w * h > 150 || (kind == 2 && (w * h < 2 || !frame_covered())))
                kind = 0;
            case (kind)
                1:       npix = w * h + $urandom_range(1, w * h);
                2:       npix = $urandom_range(1, w * h - 1);
                default: npix = w * h;
            endcase

            // pixels in raster order, the odd stale read in between
            for (int p = 0; p < npix; p++) begin
                if ($urandom_range(0, 99) < 8)
                    queue_random_read();
                queue_load(rand_pixel(), p == npix - 1);
            end

            // reads of the finished frame; one burst goes against a stalled output
            nrd = $urandom_range(3, 12);
            if (round == 3) begin
                nrd        = 40;
                hold_armed = 1'b1;
            end
            repeat (nrd) queue_random_read();
            wait_idle();
            round++;
        end

        $display("covered %0d frames: %0d pixel loads, %0d distance reads, %0d answers checked",
                 n_frames, n_loads, n_reads, n_checked);
        $display("4/8 connectivity, sizes 1 to 256 and out of range, early and overlong frames");
        if (err_cnt == 0)
            $display("two_pass_distance_transform_top_tb: clean");
        else
            $display("two_pass_distance_transform_top_tb: errors");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/tpdt_pkg.sv
rtl/core/tpdt_ram.sv
rtl/core/tpdt_ctrl.sv
rtl/core/tpdt_dpath.sv
rtl/core/two_pass_distance_transform_top.sv
test/two_pass_distance_transform_top_tb.sv
